FILE: design/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 stream decoder.
// No dependencies; imported by every design file.
package u8u16_pkg;

    localparam int UnitW     = 16;
    localparam int ByteW     = 8;
    localparam int PointW    = 21;
    localparam int QDepth    = 4;
    localparam int QPtrW     = $clog2(QDepth);
    localparam int QCntW     = $clog2(QDepth + 1);

    localparam logic [UnitW-1:0]  CapReset   = 16'd256;
    localparam logic [PointW-1:0] PointMax   = 21'h10FFFF;
    localparam logic [PointW-1:0] SuppBase   = 21'h010000;
    localparam logic [PointW-1:0] SurrLow    = 21'h00D800;
    localparam logic [PointW-1:0] SurrHigh   = 21'h00DFFF;
    localparam logic [PointW-1:0] Min2       = 21'h000080;
    localparam logic [PointW-1:0] Min3       = 21'h000800;
    localparam logic [UnitW-1:0]  HiSurrBase = 16'hD800;
    localparam logic [UnitW-1:0]  LoSurrBase = 16'hDC00;

    localparam logic [2:0] SeqLen2 = 3'd2;
    localparam logic [2:0] SeqLen3 = 3'd3;
    localparam logic [2:0] SeqLen4 = 3'd4;

    typedef struct packed {
        logic [1:0]       count;
        logic [UnitW-1:0] unit0;
        logic             last0;
        logic [UnitW-1:0] unit1;
    } dec_out_t;

endpackage

FILE: design/u8u16_core.sv
// Byte decoder: sequence state, validity checks and buffer-limit accounting.
// Produces up to two code units per accepted byte. Depends on u8u16_pkg.
module u8u16_core import u8u16_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_accept,
    input  logic [ByteW-1:0] in_byte,
    input  logic [UnitW-1:0] cap,
    output dec_out_t         dec_out
);

    logic [PointW-1:0] pp_reg, pp_next;
    logic [1:0]        pend_reg, pend_next;
    logic [2:0]        seq_reg, seq_next;
    logic [UnitW-1:0]  uw_reg, uw_next;
    logic              stop_reg, stop_next;

    logic [PointW-1:0] shifted;
    logic [PointW-1:0] minimum;
    logic [PointW-1:0] cp;
    logic [PointW-1:0] cp_off;
    logic [UnitW:0]    uw_plus2;
    logic              bad;
    logic              emit;
    logic              lead;

    assign shifted  = {pp_reg[PointW-7:0], in_byte[5:0]};
    assign uw_plus2 = {1'b0, uw_reg} + 17'd2;

    always_comb begin
        case (seq_reg)
            SeqLen2: minimum = Min2;
            SeqLen3: minimum = Min3;
            SeqLen4: minimum = SuppBase;
            default: minimum = '0;
        endcase
    end

    assign bad = (shifted < minimum) || (shifted > PointMax) ||
                 ((shifted >= SurrLow) && (shifted <= SurrHigh));

    always_comb begin
        pp_next   = pp_reg;
        pend_next = pend_reg;
        seq_next  = seq_reg;
        uw_next   = uw_reg;
        stop_next = stop_reg;
        dec_out   = '0;
        emit      = 1'b0;
        lead      = 1'b0;
        cp        = '0;
        cp_off    = '0;
        if (in_accept) begin
            if (in_byte == '0) begin
                dec_out.count = 2'd1;
                dec_out.last0 = 1'b1;
                pp_next   = '0;
                pend_next = '0;
                seq_next  = '0;
                uw_next   = '0;
                stop_next = 1'b0;
            end else begin
                lead = 1'b1;
                if (pend_reg != 2'd0) begin
                    if (in_byte[7:6] == 2'b10) begin
                        lead      = 1'b0;
                        pp_next   = shifted;
                        pend_next = pend_reg - 2'd1;
                        if (pend_reg == 2'd1) begin
                            pp_next  = '0;
                            seq_next = '0;
                            if (!bad) begin
                                emit = 1'b1;
                                cp   = shifted;
                            end
                        end
                    end else begin
                        pp_next   = '0;
                        pend_next = '0;
                        seq_next  = '0;
                    end
                end
                if (lead) begin
                    if (in_byte[7] == 1'b0) begin
                        emit = 1'b1;
                        cp   = {{(PointW-ByteW){1'b0}}, in_byte};
                    end else if (in_byte[7:5] == 3'b110) begin
                        pp_next   = {{(PointW-5){1'b0}}, in_byte[4:0]};
                        pend_next = 2'd1;
                        seq_next  = SeqLen2;
                    end else if (in_byte[7:4] == 4'b1110) begin
                        pp_next   = {{(PointW-4){1'b0}}, in_byte[3:0]};
                        pend_next = 2'd2;
                        seq_next  = SeqLen3;
                    end else if (in_byte[7:3] == 5'b11110) begin
                        pp_next   = {{(PointW-3){1'b0}}, in_byte[2:0]};
                        pend_next = 2'd3;
                        seq_next  = SeqLen4;
                    end
                end
                if (emit && !stop_reg) begin
                    if (cp >= SuppBase) begin
                        if (uw_plus2 >= {1'b0, cap}) begin
                            stop_next = 1'b1;
                        end else begin
                            cp_off        = cp - SuppBase;
                            dec_out.count = 2'd2;
                            dec_out.unit0 = HiSurrBase + {6'b0, cp_off[19:10]};
                            dec_out.unit1 = LoSurrBase + {6'b0, cp_off[9:0]};
                            uw_next       = uw_plus2[UnitW-1:0];
                        end
                    end else if ((cap != '0) && (uw_reg < cap - 16'd1)) begin
                        dec_out.count = 2'd1;
                        dec_out.unit0 = cp[UnitW-1:0];
                        uw_next       = uw_reg + 16'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pp_reg   <= '0;
            pend_reg <= '0;
            seq_reg  <= '0;
            uw_reg   <= '0;
            stop_reg <= 1'b0;
        end else begin
            pp_reg   <= pp_next;
            pend_reg <= pend_next;
            seq_reg  <= seq_next;
            uw_reg   <= uw_next;
            stop_reg <= stop_next;
        end
    end

    a_zero_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && in_byte == '0) |=> (uw_reg == '0 && pend_reg == 2'd0 && !stop_reg))
        else $error("terminator did not clear decoder state");

    a_stopped_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (stop_reg && dec_out.count != 2'd0) |-> dec_out.last0)
        else $error("unit emitted after output stopped");

    a_pend_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg != 2'd0) |-> (seq_reg == SeqLen2 || seq_reg == SeqLen3 ||
                                seq_reg == SeqLen4))
        else $error("pending bytes without an open sequence");

endmodule

FILE: design/u8u16_ofifo.sv
// Result queue: takes up to two code units per cycle, delivers one per word.
// Depends on u8u16_pkg.
module u8u16_ofifo import u8u16_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  dec_out_t         push,
    output logic             in_ready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [UnitW-1:0] m_tdata,
    output logic             m_tlast
);

    logic [UnitW:0]   mem_reg [QDepth];
    logic [QPtrW-1:0] head_reg, head_next;
    logic [QPtrW-1:0] tail_reg, tail_next;
    logic [QCntW-1:0] cnt_reg, cnt_next;
    logic [QPtrW-1:0] tail_p1;
    logic             pop;

    assign tail_p1  = tail_reg + 1'b1;
    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = mem_reg[head_reg][UnitW-1:0];
    assign m_tlast  = mem_reg[head_reg][UnitW];
    assign in_ready = (cnt_reg <= QCntW'(QDepth - 2));

    always_comb begin
        head_next = pop ? head_reg + 1'b1 : head_reg;
        tail_next = tail_reg + QPtrW'(push.count);
        cnt_next  = cnt_reg + QCntW'(push.count) - QCntW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[tail_reg] <= {push.last0, push.unit0};
        end
        if (push.count == 2'd2) begin
            mem_reg[tail_p1] <= {1'b0, push.unit1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0) |-> (cnt_reg <= QCntW'(QDepth - 2)))
        else $error("push into full result queue");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QCntW'(QDepth))
        else $error("result queue count out of range");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        QPtrW'(tail_reg - head_reg) == cnt_reg[QPtrW-1:0])
        else $error("queue pointers disagree with count");

endmodule

FILE: design/utf8_to_utf16_decoder_top.sv
// Top level of the UTF-8 to UTF-16 stream decoder.
// Instantiates u8u16_core and u8u16_ofifo; depends on u8u16_pkg.
//
// Usage:
//   s_* channel carries one UTF-8 byte per word; a zero byte ends the string.
//   m_* channel carries one UTF-16 code unit per word; m_tlast marks the zero
//   terminator unit of each string. Supplementary characters leave as a
//   surrogate pair on two consecutive words.
//   cfg_wr_en / cfg_wr_data set the output buffer size in units (terminator
//   included); write only while the block is idle. Reset value 256.
// Timing:
//   One byte is taken per cycle while s_tready is high. The units that a byte
//   produces enter the result queue when the byte is accepted and leave on m_*
//   from there; a four-entry result queue absorbs surrogate pairs.
// Reset and stall:
//   aresetn clears the decoder state and the queue, and sets the capacity register to 256.
//   When the receiver stalls, s_tready drops once fewer than two queue slots
//   remain free; no word is lost.
module utf8_to_utf16_decoder_top import u8u16_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [UnitW-1:0] cfg_wr_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [ByteW-1:0] s_tdata,   // [7:0] in_byte
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [UnitW-1:0] m_tdata,   // [15:0] code_unit
    output logic             m_tlast
);

    logic [UnitW-1:0] cap_reg;
    dec_out_t         dec_out;
    logic             in_accept;

    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CapReset;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    u8u16_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .cap       (cap_reg),
        .dec_out   (dec_out)
    );

    u8u16_ofifo u_ofifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (dec_out),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
